FILE: hdl/hsvr_pkg.sv
// hsvr_pkg: types and constants shared by the rainbow hsv to rgb pipeline
// no dependencies
`default_nettype none

package hsvr_pkg;

    localparam logic [14:0] RAMP_MUL  = 15'd21846;
    localparam logic [15:0] SCALE_MAX = 16'hFFFF;
    localparam logic [16:0] VAL_BIAS  = 17'd512;

    localparam logic [2:0] SEC_RED    = 3'd0;
    localparam logic [2:0] SEC_ORANGE = 3'd1;
    localparam logic [2:0] SEC_YELLOW = 3'd2;
    localparam logic [2:0] SEC_GREEN  = 3'd3;
    localparam logic [2:0] SEC_AQUA   = 3'd4;
    localparam logic [2:0] SEC_BLUE   = 3'd5;
    localparam logic [2:0] SEC_PURPLE = 3'd6;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_CLAMP,
        MODE_SCALE
    } t_mode;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        t_rgb        base;
        logic [15:0] scale;
        logic [7:0]  floor8;
        t_mode       sat_mode;
        t_mode       val_mode;
        logic [16:0] m;
    } t_mid;

    typedef struct packed {
        t_rgb        chan;
        t_mode       val_mode;
        logic [16:0] m;
    } t_sat;

endpackage

`default_nettype wire

FILE: hdl/hsvr_front.sv
// hsvr_front: first two stages, hue ramp product, section base colours,
// saturation and value factors; depends on hsvr_pkg
`default_nettype none

module hsvr_front
    import hsvr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en1,
    input  wire logic        i_en2,
    input  wire logic [15:0] i_hue,
    input  wire logic [7:0]  i_sat,
    input  wire logic [7:0]  i_val,
    output t_mid             o_mid
);

    logic [27:0] r_ramp, n_ramp;
    logic [2:0]  r_sect;
    logic [15:0] r_d, n_d;
    logic [16:0] r_m, n_m;
    t_mode       r_sat_mode, n_sat_mode;
    t_mode       r_val_mode, n_val_mode;
    t_mid        r_mid, n_mid;
    logic [7:0]  ds;
    logic [7:0]  t;
    logic [7:0]  t2;

    always_comb begin
        ds     = 8'd255 - i_sat;
        n_ramp = 28'(i_hue[12:0]) * 28'(RAMP_MUL);
        n_d    = 16'(ds) * 16'(ds);
        n_m    = 17'(i_val) * 17'(i_val) + VAL_BIAS;
        if (i_sat == 8'd255) begin
            n_sat_mode = MODE_PASS;
        end else if (i_sat == 8'd0) begin
            n_sat_mode = MODE_CLAMP;
        end else begin
            n_sat_mode = MODE_SCALE;
        end
        if (i_val == 8'd255) begin
            n_val_mode = MODE_PASS;
        end else if (i_val == 8'd0) begin
            n_val_mode = MODE_CLAMP;
        end else begin
            n_val_mode = MODE_SCALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_ramp     <= n_ramp;
            r_sect     <= i_hue[15:13];
            r_d        <= n_d;
            r_m        <= n_m;
            r_sat_mode <= n_sat_mode;
            r_val_mode <= n_val_mode;
        end
    end

    always_comb begin
        t  = {1'b0, r_ramp[27:21]};
        t2 = r_ramp[27:20];
        n_mid.scale    = SCALE_MAX - r_d;
        n_mid.floor8   = r_d[15:8];
        n_mid.sat_mode = r_sat_mode;
        n_mid.val_mode = r_val_mode;
        n_mid.m        = r_m;
        case (r_sect)
            SEC_RED: begin
                n_mid.base = '{r: 8'd255 - t, g: t, b: 8'd0};
            end
            SEC_ORANGE: begin
                n_mid.base = '{r: 8'd171, g: 8'd85 + t, b: 8'd0};
            end
            SEC_YELLOW: begin
                n_mid.base = '{r: 8'd171 - t2, g: 8'd170 + t, b: 8'd0};
            end
            SEC_GREEN: begin
                n_mid.base = '{r: 8'd0, g: 8'd255 - t, b: t};
            end
            SEC_AQUA: begin
                n_mid.base = '{r: 8'd0, g: 8'd171 - t2, b: 8'd85 + t2};
            end
            SEC_BLUE: begin
                n_mid.base = '{r: t, g: 8'd0, b: 8'd255 - t};
            end
            SEC_PURPLE: begin
                n_mid.base = '{r: 8'd85 + t, g: 8'd0, b: 8'd171 - t};
            end
            default: begin
                n_mid.base = '{r: 8'd170 + t, g: 8'd0, b: 8'd85 - t};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid = r_mid;

endmodule

`default_nettype wire

FILE: hdl/hsvr_sat.sv
// hsvr_sat: third stage, pulls the base colour towards white by saturation
// depends on hsvr_pkg
`default_nettype none

module hsvr_sat
    import hsvr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_mid i_mid,
    output t_sat      o_sat
);

    t_sat r_sat, n_sat;

    function automatic logic [7:0] sat_ch(input logic [7:0] c, input t_mode mode,
                                          input logic [15:0] scale,
                                          input logic [7:0] floor8);
        logic [23:0] p;
        p = 24'(c) * 24'(scale);
        case (mode)
            MODE_PASS:  sat_ch = c;
            MODE_CLAMP: sat_ch = 8'd255;
            default:    sat_ch = p[23:16] + floor8;
        endcase
    endfunction

    always_comb begin
        n_sat.chan.r   = sat_ch(i_mid.base.r, i_mid.sat_mode, i_mid.scale, i_mid.floor8);
        n_sat.chan.g   = sat_ch(i_mid.base.g, i_mid.sat_mode, i_mid.scale, i_mid.floor8);
        n_sat.chan.b   = sat_ch(i_mid.base.b, i_mid.sat_mode, i_mid.scale, i_mid.floor8);
        n_sat.val_mode = i_mid.val_mode;
        n_sat.m        = i_mid.m;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat <= n_sat;
        end
    end

    assign o_sat = r_sat;

endmodule

`default_nettype wire

FILE: hdl/hsvr_val.sv
// hsvr_val: last stage, brightness scaling and output channel order
// depends on hsvr_pkg
`default_nettype none

module hsvr_val
    import hsvr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire logic i_swap,
    input  wire t_sat i_sat,
    output t_rgb      o_rgb
);

    t_rgb r_rgb, n_rgb;
    t_rgb adj;

    function automatic logic [7:0] val_ch(input logic [7:0] c, input t_mode mode,
                                          input logic [16:0] m);
        logic [24:0] p;
        p = 25'(c) * 25'(m);
        case (mode)
            MODE_PASS:  val_ch = c;
            MODE_CLAMP: val_ch = 8'd0;
            default:    val_ch = (c == 8'd0) ? 8'd0 : p[23:16] + 8'd1;
        endcase
    endfunction

    always_comb begin
        adj.r = val_ch(i_sat.chan.r, i_sat.val_mode, i_sat.m);
        adj.g = val_ch(i_sat.chan.g, i_sat.val_mode, i_sat.m);
        adj.b = val_ch(i_sat.chan.b, i_sat.val_mode, i_sat.m);
        if (i_swap) begin
            n_rgb = '{r: adj.b, g: adj.g, b: adj.r};
        end else begin
            n_rgb = adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

`default_nettype wire

FILE: hdl/hsv_rainbow_to_rgb.sv
// hsv_rainbow_to_rgb: top level, four stage rainbow hsv to rgb converter
// depends on hsvr_pkg, hsvr_front, hsvr_sat, hsvr_val
//
// usage:
// s_axis carries one hsv pixel per request, m_axis one rgb pixel per request.
// cfg channel writes the red/blue swap bit; o_cfg_ready is high outside reset and
// the bit should only change while the pipeline holds no pixel.
// the result leaves through four register stages: ramp and squares, section
// colours, saturation multiply, brightness multiply and reorder; m_axis_tvalid
// rises when the pixel reaches the last stage. throughput is one pixel per
// clock while m_axis_tready stays high.
// each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so bubbles are squeezed out and input is taken while a
// finished pixel waits at the output.
// when m_axis_tready is low the output holds; the stages behind keep filling
// until full, then s_axis_tready drops. nothing is lost or repeated.
// synchronous active low reset empties every stage and clears the swap bit;
// s_axis_tready and o_cfg_ready stay low while reset is held.
`default_nettype none

module hsv_rainbow_to_rgb
    import hsvr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // hue[15:0], saturation[23:16], brightness[31:24]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // channel_first, channel_second, channel_third
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    localparam int NSTAGE = 4;

    logic [NSTAGE-1:0] r_vld, n_vld;
    logic [NSTAGE-1:0] rdy;
    logic              r_swap;
    t_mid              mid;
    t_sat              sat;
    t_rgb              rgb;

    always_comb begin
        rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_swap <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_valid) begin
                r_swap <= i_cfg_data;
            end
        end
    end

    hsvr_front u_front (
        .i_clk (i_clk),
        .i_en1 (rdy[0]),
        .i_en2 (rdy[1]),
        .i_hue (s_axis_tdata[15:0]),
        .i_sat (s_axis_tdata[23:16]),
        .i_val (s_axis_tdata[31:24]),
        .o_mid (mid)
    );

    hsvr_sat u_sat (
        .i_clk (i_clk),
        .i_en  (rdy[2]),
        .i_mid (mid),
        .o_sat (sat)
    );

    hsvr_val u_val (
        .i_clk  (i_clk),
        .i_en   (rdy[3]),
        .i_swap (r_swap),
        .i_sat  (sat),
        .o_rgb  (rgb)
    );

    assign s_axis_tready = rdy[0] && i_rst_n;
    assign m_axis_tvalid = r_vld[NSTAGE-1];
    assign m_axis_tdata  = {rgb.b, rgb.g, rgb.r};
    assign o_cfg_ready   = i_rst_n;

endmodule

`default_nettype wire

FILE: sim/hsv_rainbow_to_rgb_tb.sv
// hsv_rainbow_to_rgb_tb: self-checking bench for the rainbow hsv to rgb converter
// drives stream pixels and swap register, predicts untyped rgb results in the bench
// depends on hsvr_pkg and hsv_rainbow_to_rgb
`default_nettype none

module hsv_rainbow_to_rgb_tb
    import hsvr_pkg::*;
();

    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_PIXELS = 166;
    localparam int PHASES       = 5;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        bit          typed;
        logic [23:0] rgb;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // hue[15:0], saturation[23:16], brightness[31:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // channel_first, channel_second, channel_third
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    logic [23:0] pending_rgb[$];
    logic        swap_copy;
    bit          send_busy;
    bit          recv_busy;
    bit          long_hold;
    int          errors;
    int          pixels_sent;
    int          pixels_checked;
    int          cfg_writes;
    int          idle_cycles;
    string       field_name[3] = '{"channel_first", "channel_second", "channel_third"};

    // the typed rows hold their result with channel_first in the low byte
    t_row directed_rows[] = '{
        '{16'h0000, 8'd255, 8'd255, 1'b1, 24'h0000FF},
        '{16'h2000, 8'd255, 8'd255, 1'b1, 24'h0055AB},
        '{16'h4000, 8'd255, 8'd255, 1'b1, 24'h00AAAB},
        '{16'h6000, 8'd255, 8'd255, 1'b1, 24'h00FF00},
        '{16'h8000, 8'd255, 8'd255, 1'b1, 24'h55AB00},
        '{16'hA000, 8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{16'hC000, 8'd255, 8'd255, 1'b1, 24'hAB0055},
        '{16'hE000, 8'd255, 8'd255, 1'b1, 24'h5500AA},
        '{16'h1234, 8'd0,   8'd255, 1'b1, 24'hFFFFFF},
        '{16'hFFFF, 8'd0,   8'd0,   1'b1, 24'h000000},
        '{16'h6000, 8'd255, 8'd0,   1'b1, 24'h000000},
        '{16'hFFFF, 8'd255, 8'd255, 1'b0, 24'h0},
        '{16'h1FFF, 8'd255, 8'd255, 1'b0, 24'h0},
        '{16'h5FFF, 8'd255, 8'd255, 1'b0, 24'h0},
        '{16'h9FFF, 8'd1,   8'd255, 1'b0, 24'h0},
        '{16'h3A5C, 8'd254, 8'd255, 1'b0, 24'h0},
        '{16'hA000, 8'd255, 8'd1,   1'b0, 24'h0},
        '{16'hC5A5, 8'd255, 8'd254, 1'b0, 24'h0},
        '{16'h7FFF, 8'd200, 8'd17,  1'b0, 24'h0},
        '{16'h9ABC, 8'd128, 8'd128, 1'b0, 24'h0},
        '{16'hDFFF, 8'd1,   8'd1,   1'b0, 24'h0},
        '{16'h0001, 8'd254, 8'd254, 1'b0, 24'h0}
    };

    hsv_rainbow_to_rgb u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [23:0] rainbow_rgb(logic [15:0] hue, logic [7:0] sat,
                                                logic [7:0] val, logic swap);
        logic [31:0] ramp;
        logic [31:0] desat;
        logic [31:0] scale;
        logic [31:0] bright;
        logic [31:0] prod;
        logic [7:0]  t;
        logic [7:0]  t2;
        logic [7:0]  floor8;
        logic [7:0]  ch[3];
        ramp = {19'd0, hue[12:0]} * 32'd21846;
        t    = ramp[28:21];
        t2   = ramp[27:20];
        case (hue[15:13])
            SEC_RED:    begin ch[0] = 8'd255 - t;  ch[1] = t;           ch[2] = 8'd0;       end
            SEC_ORANGE: begin ch[0] = 8'd171;      ch[1] = 8'd85 + t;   ch[2] = 8'd0;       end
            SEC_YELLOW: begin ch[0] = 8'd171 - t2; ch[1] = 8'd170 + t;  ch[2] = 8'd0;       end
            SEC_GREEN:  begin ch[0] = 8'd0;        ch[1] = 8'd255 - t;  ch[2] = t;          end
            SEC_AQUA:   begin ch[0] = 8'd0;        ch[1] = 8'd171 - t2; ch[2] = 8'd85 + t2; end
            SEC_BLUE:   begin ch[0] = t;           ch[1] = 8'd0;        ch[2] = 8'd255 - t; end
            SEC_PURPLE: begin ch[0] = 8'd85 + t;   ch[1] = 8'd0;        ch[2] = 8'd171 - t; end
            default:    begin ch[0] = 8'd170 + t;  ch[1] = 8'd0;        ch[2] = 8'd85 - t;  end
        endcase
        if (sat == 8'd0) begin
            ch = '{8'd255, 8'd255, 8'd255};
        end else if (sat != 8'd255) begin
            desat  = (32'd255 - sat) * (32'd255 - sat);
            scale  = 32'hFFFF - desat;
            floor8 = desat[15:8];
            for (int k = 0; k < 3; k++) begin
                prod  = ch[k] * scale;
                ch[k] = prod[23:16] + floor8;
            end
        end
        if (val == 8'd0) begin
            ch = '{8'd0, 8'd0, 8'd0};
        end else if (val != 8'd255) begin
            bright = val * val + 32'd512;
            for (int k = 0; k < 3; k++) begin
                prod = ch[k] * bright;
                if (ch[k] != 8'd0)
                    ch[k] = prod[23:16] + 8'd1;
            end
        end
        return swap ? {ch[0], ch[1], ch[2]} : {ch[2], ch[1], ch[0]};
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_hue();
        logic [2:0] sec;
        sec = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       return {sec, 13'h0000};
            1:       return {sec, 13'h1FFF};
            2:       return {sec, 13'($urandom_range(0, 15))};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                              input logic [7:0] val, input int gap,
                              input bit typed, input logic [23:0] typed_rgb);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, sat, hue};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_rgb.push_back(typed ? typed_rgb : rainbow_rgb(hue, sat, val, swap_copy));
        pixels_sent++;
    endtask

    task automatic write_swap(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        swap_copy = value;
        cfg_writes++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus: directed rows at reset setting, then random phases with swap changes
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;
        swap_copy      = 1'b0;
        send_busy      = 1'b0;
        recv_busy      = 1'b0;
        long_hold      = 1'b0;
        errors         = 0;
        pixels_sent    = 0;
        cfg_writes     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val,
                       $urandom_range(0, 3), directed_rows[i].typed, directed_rows[i].rgb);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_swap(p[0] ? 1'b0 : 1'b1);
            send_busy = (p == 1) || (p == 2);
            recv_busy = (p == 1) || (p == 3);
            long_hold = (p == 2);
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(pick_hue(), pick_level(), pick_level(),
                           send_busy ? 0 : $urandom_range(0, 17), 1'b0, 24'h0);
            drain();
        end

        $display("%0d pixels over all eight sections and saturation/brightness extremes,",
                 pixels_sent);
        $display("%0d results checked, %0d swap writes, one long output stall",
                 pixels_checked, cfg_writes);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // output: random hold-off per request unless recv_busy, one long stall if asked
    initial begin
        int wait_cycles;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            wait_cycles = recv_busy ? 0 : $urandom_range(0, 17);
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial pixels_checked = 0;

    always @(posedge i_clk) begin : result_check
        logic [23:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rgb.size() == 0) begin
                $error("output request with no pixel pending: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_rgb.pop_front();
                pixels_checked++;
                for (int k = 0; k < 3; k++)
                    if (m_axis_tdata[k*8 +: 8] !== want[k*8 +: 8]) begin
                        $error("%s expected %0d actual %0d", field_name[k],
                               want[k*8 +: 8], m_axis_tdata[k*8 +: 8]);
                        errors++;
                    end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_rgb.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire
